// ----- sv/cta_pkg.sv -----
// Package: shared widths, codes and defaults for the capacity target allocator.
`timescale 1ns / 1ps
`default_nettype none

package cta_pkg;

    localparam int NUM_TARGETS_DEF = 16;

    localparam int TARGET_W = 4;
    localparam int CAP_W    = 32;
    localparam int MASK_W   = 16;
    localparam int STRAT_W  = 2;

    // APB register map
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_STRATEGY = 1'b0;

    // strategy codes
    localparam logic [STRAT_W-1:0] STRAT_GREEDY  = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_HIGHEST = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_LOWEST  = 2'd2;

    // request type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

endpackage

`default_nettype wire

// ----- sv/cta_if.sv -----
// Interfaces: request and response channels of the allocator.
`timescale 1ns / 1ps
`default_nettype none

interface cta_req_if;
    import cta_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [TARGET_W-1:0] target_index;
    logic [CAP_W-1:0]    load_capacity;
    logic                load_present;
    logic [CAP_W-1:0]    demand;
    logic [MASK_W-1:0]   candidate_mask;

    modport source (
        output valid, req_type, target_index, load_capacity, load_present, demand,
               candidate_mask,
        input  ready
    );

    modport sink (
        input  valid, req_type, target_index, load_capacity, load_present, demand,
               candidate_mask,
        output ready
    );
endinterface

interface cta_rsp_if;
    import cta_pkg::*;

    logic                valid;
    logic                ready;
    logic                granted;
    logic [TARGET_W-1:0] chosen_target;
    logic [CAP_W-1:0]    remaining;

    modport source (
        output valid, granted, chosen_target, remaining,
        input  ready
    );

    modport sink (
        input  valid, granted, chosen_target, remaining,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/cta_cfg.sv -----
// APB register block holding the allocation strategy.
`timescale 1ns / 1ps
`default_nettype none

module cta_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [cta_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [cta_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [cta_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [cta_pkg::STRAT_W-1:0]      strategy
);
    import cta_pkg::*;

    logic [STRAT_W-1:0]   strategy_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= STRAT_GREEDY;
        end
        else if (wr_en && reg_idx == REG_STRATEGY)
        begin
            strategy_reg <= pwdata[STRAT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_STRATEGY: prdata = {{(CFG_DATA_W-STRAT_W){1'b0}}, strategy_reg};
            default:      prdata = '0;
        endcase
    end

    assign strategy = strategy_reg;

endmodule

`default_nettype wire

// ----- sv/cta_engine.sv -----
// Allocation engine: capacity memory, present flags and the scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

module cta_engine #(
    parameter int NUM_TARGETS = cta_pkg::NUM_TARGETS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [cta_pkg::STRAT_W-1:0] strategy,
    cta_req_if.sink                          req,
    cta_rsp_if.source                        rsp
);
    import cta_pkg::*;

    localparam int IDX_W = $clog2(NUM_TARGETS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TARGETS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CAP_W-1:0] cap_mem [NUM_TARGETS];
    logic [CAP_W-1:0] rdata_reg;

    logic [NUM_TARGETS-1:0] present_reg;
    logic [NUM_TARGETS-1:0] cand_reg;
    logic [CAP_W-1:0]       dem_reg;
    logic [STRAT_W-1:0]     strat_reg;

    logic [IDX_W-1:0] scan_cnt_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic             best_valid_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [CAP_W-1:0] best_cap_reg;

    logic                out_valid_reg;
    logic                out_granted_reg;
    logic [TARGET_W-1:0] out_target_reg;
    logic [CAP_W-1:0]    out_remaining_reg;

    logic                          out_free;
    logic                          accept;
    logic                          is_load;
    logic                          load_ok;
    logic                          strat_bad;
    logic [NUM_TARGETS+MASK_W-1:0] mask_ext;
    logic                          take;
    logic [CAP_W-1:0]              new_cap;
    logic                          finish;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CAP_W-1:0] mem_wdata;
    logic             mem_re;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign is_load   = (req.req_type == REQ_LOAD);
    assign load_ok   = (32'(req.target_index) < NUM_TARGETS);
    assign strat_bad = (strategy != STRAT_GREEDY) && (strategy != STRAT_HIGHEST)
                       && (strategy != STRAT_LOWEST);
    assign mask_ext  = {{NUM_TARGETS{1'b0}}, req.candidate_mask};
    assign finish    = (state_reg == S_DONE) && out_free;
    assign new_cap   = best_cap_reg - dem_reg;

    // candidate evaluation on the word read in the previous cycle
    always_comb
    begin
        take = 1'b0;
        if (rd_vld_reg && present_reg[rd_idx_reg] && cand_reg[rd_idx_reg]
            && (dem_reg <= rdata_reg))
        begin
            if (!best_valid_reg)
                take = 1'b1;
            else if (strat_reg == STRAT_HIGHEST && rdata_reg > best_cap_reg)
                take = 1'b1;
            else if (strat_reg == STRAT_LOWEST && rdata_reg < best_cap_reg)
                take = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !is_load && !strat_bad)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == LAST_IDX)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // single write port: loads at accept, write-back at the end of a scan
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = IDX_W'(req.target_index);
        mem_wdata = req.load_capacity;
        if (accept && is_load && load_ok)
            mem_we = 1'b1;
        else if (finish && best_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = new_cap;
        end
    end

    assign mem_re = (state_reg == S_SCAN);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cap_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= cap_mem[scan_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            present_reg    <= '0;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= mem_re;

            if (accept && is_load && load_ok)
                present_reg[IDX_W'(req.target_index)] <= req.load_present;

            if (state_reg == S_SCAN)
                scan_cnt_reg <= (scan_cnt_reg == LAST_IDX) ? '0 : scan_cnt_reg + 1'b1;
            else
                scan_cnt_reg <= '0;

            if (accept)
                best_valid_reg <= 1'b0;
            else if (take)
                best_valid_reg <= 1'b1;

            if (accept || finish)
                out_valid_reg <= accept ? (is_load || strat_bad) : 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_cnt_reg;
        if (accept)
        begin
            cand_reg  <= mask_ext[NUM_TARGETS-1:0];
            dem_reg   <= req.demand;
            strat_reg <= strategy;
        end
        if (take)
        begin
            best_idx_reg <= rd_idx_reg;
            best_cap_reg <= rdata_reg;
        end
        if (accept && is_load)
        begin
            out_granted_reg   <= load_ok;
            out_target_reg    <= req.target_index;
            out_remaining_reg <= load_ok ? req.load_capacity : '0;
        end
        else if (accept)
        begin
            out_granted_reg   <= 1'b0;
            out_target_reg    <= '0;
            out_remaining_reg <= '0;
        end
        else if (finish)
        begin
            out_granted_reg   <= best_valid_reg;
            out_target_reg    <= best_valid_reg ? TARGET_W'(best_idx_reg) : '0;
            out_remaining_reg <= best_valid_reg ? new_cap : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted       = out_granted_reg;
    assign rsp.chosen_target = out_target_reg;
    assign rsp.remaining     = out_remaining_reg;

`ifndef SYNTHESIS
    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && best_valid_reg) |-> (dem_reg <= best_cap_reg))
        else $error("chosen target does not fit the demand");

    a_best_present: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && best_valid_reg) |-> present_reg[best_idx_reg] && cand_reg[best_idx_reg])
        else $error("chosen target is not a present candidate");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (rsp.valid && state_reg == S_IDLE))
        else $error("scan finished without a response");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("request taken during a scan");
`endif

endmodule

`default_nettype wire

// ----- sv/capacity_target_allocator.sv -----
// Load request or bad strategy: result registered at the accepting edge.
// Allocate request: the single memory read port visits one capacity entry
// per cycle in the scan state, the drain state judges the last word, then
// the done state writes back and also registers the result.
// One request in flight; a new one can be taken as the result is taken.
// Reset: present flags cleared, strategy greedy; the capacity memory is
// not cleared, an entry's word is only used after it has been loaded present.
`timescale 1ns / 1ps
`default_nettype none

module capacity_target_allocator #(
    parameter int NUM_TARGETS = cta_pkg::NUM_TARGETS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cta_req_if.sink                             req,
    cta_rsp_if.source                           rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cta_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [cta_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [cta_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import cta_pkg::*;

    logic [STRAT_W-1:0] strategy;

    cta_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .strategy (strategy)
    );

    cta_engine #(
        .NUM_TARGETS (NUM_TARGETS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .strategy (strategy),
        .req      (req),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire
